/* src/tda_pkg.sv */
// tda_pkg: shared types and constants for the tick/deadline accumulator.
// Request/result structs, register indexes, reset values, datapath widths.
// No dependencies.
package tda_pkg;

    localparam int DATA_W  = 32;
    localparam int TPS_W   = 10;
    localparam int LAG_W   = 8;
    localparam int NUM_W   = DATA_W + TPS_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EMU_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG  = 2'd2;

    localparam logic [DATA_W-1:0] EMU_RATE_RST = 32'd3500000;
    localparam logic [TPS_W-1:0]  TICKS_PS_RST = 10'd100;
    localparam logic [LAG_W-1:0]  MAX_LAG_RST  = 8'd4;

    typedef struct packed {
        logic [DATA_W-1:0] elapsed_cycles;
        logic [DATA_W-1:0] host_now;
    } in_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] whole_ticks;
        logic [DATA_W-1:0] deadline_time;
        logic              deadline_set;
    } out_res_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [TPS_W-1:0]  b;
        logic [DATA_W-1:0] c;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] den;
    } div_req_t;

endpackage

/* src/tda_serial_mult.sv */
// tda_serial_mult: bit-serial multiply-add, a * b + c, one bit of b per cycle.
// After start, done pulses with the product valid.
// Depends on tda_pkg.
module tda_serial_mult
    import tda_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  mul_req_t         req,
    output logic             done,
    output logic [NUM_W-1:0] prod
);

    localparam int CNT_W = $clog2(TPS_W);

    logic [NUM_W-1:0] acc_reg;
    logic [NUM_W-1:0] a_reg;
    logic [TPS_W-1:0] b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TPS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= NUM_W'(req.c);
            a_reg   <= NUM_W'(req.a);
            b_reg   <= req.b;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[NUM_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[TPS_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* src/tda_serial_div.sv */
// tda_serial_div: restoring divider, one quotient bit per cycle.
// Keeps the low DATA_W quotient bits and the remainder. Divisor must be nonzero.
// Depends on tda_pkg.
module tda_serial_div
    import tda_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req,
    output logic              done,
    output logic [DATA_W-1:0] quot,
    output logic [DATA_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0]  num_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              qbit;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = !diff[DATA_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            quot_reg <= {quot_reg[DATA_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

/* src/tstate_deadline_accumulator_core.sv */
// tstate_deadline_accumulator_core: top level of the tick/deadline accumulator.
// Instantiates tda_serial_mult and tda_serial_div; depends on tda_pkg.
//
//  channel   ports                                  direction
//  input     s_valid, s_ready, s_req (in_req_t)     request in
//  result    m_valid, m_ready, m_res (out_res_t)    result out
//  config    cfg_valid, cfg_ready, cfg_index/data   register write in
//
// One request at a time: accept, serial multiply, handoff to the serial divide, then
// update and output. When a deadline is already set and the quotient is nonzero,
// a serial lag product (quotient times max lag) follows the divide before output.
// Synchronous active-low reset restores register defaults and clears state.
// A finished result waits in the output register; a new request is taken
// meanwhile, and the next result stalls only until m_ready frees it.
module tstate_deadline_accumulator_core
    import tda_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_req_t              s_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_res_t             m_res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_DIV, S_MUL2, S_OUT} state_t;

    state_t                state_reg;
    logic [DATA_W-1:0]     emu_rate_reg;
    logic [TPS_W-1:0]      ticks_ps_reg;
    logic [LAG_W-1:0]      max_lag_reg;
    logic [DATA_W-1:0]     fraction_reg;
    logic [TIME_BITS-1:0]  deadline_reg;
    logic                  dl_valid_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [DATA_W-1:0]     ticks_reg;
    logic                  m_valid_reg;
    out_res_t              m_res_reg;

    mul_req_t              mul_req;
    div_req_t              div_req;
    logic                  mul_done;
    logic [NUM_W-1:0]      mul_prod;
    logic                  div_done;
    logic [DATA_W-1:0]     div_quot;
    logic [DATA_W-1:0]     div_rem;
    logic [DATA_W-1:0]     rate_eff;
    logic [TIME_BITS-1:0]  lag;
    logic [TIME_BITS-1:0]  lead;
    logic                  out_free;

    assign rate_eff  = (emu_rate_reg == '0) ? DATA_W'(1) : emu_rate_reg;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign lag       = mul_prod[TIME_BITS-1:0];
    assign lead      = now_reg - deadline_reg;

    always_comb begin
        mul_req = '0;
        if (state_reg == S_IDLE && s_valid) begin
            mul_req.start = 1'b1;
            mul_req.a     = s_req.elapsed_cycles;
            mul_req.b     = ticks_ps_reg;
            mul_req.c     = fraction_reg;
        end else if (state_reg == S_DIV && div_done && div_quot != '0 && dl_valid_reg) begin
            mul_req.start = 1'b1;
            mul_req.a     = div_quot;
            mul_req.b     = TPS_W'(max_lag_reg);
        end
    end

    always_comb begin
        div_req       = '0;
        div_req.start = (state_reg == S_MUL1) && mul_done;
        div_req.num   = mul_prod;
        div_req.den   = rate_eff;
    end

    tda_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    tda_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            emu_rate_reg <= EMU_RATE_RST;
            ticks_ps_reg <= TICKS_PS_RST;
            max_lag_reg  <= MAX_LAG_RST;
            fraction_reg <= '0;
            deadline_reg <= '0;
            dl_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_EMU_RATE: emu_rate_reg <= cfg_data;
                    CFG_TICKS_PS: ticks_ps_reg <= cfg_data[TPS_W-1:0];
                    CFG_MAX_LAG:  max_lag_reg  <= cfg_data[LAG_W-1:0];
                    default: ;
                endcase
            end

            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        now_reg   <= s_req.host_now[TIME_BITS-1:0];
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    if (mul_done) begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        fraction_reg <= div_rem;
                        ticks_reg    <= div_quot;
                        if (div_quot == '0) begin
                            state_reg <= S_OUT;
                        end else if (!dl_valid_reg) begin
                            deadline_reg <= now_reg + div_quot[TIME_BITS-1:0];
                            dl_valid_reg <= 1'b1;
                            state_reg    <= S_OUT;
                        end else begin
                            deadline_reg <= deadline_reg + div_quot[TIME_BITS-1:0];
                            state_reg    <= S_MUL2;
                        end
                    end
                end
                S_MUL2: begin
                    if (mul_done) begin
                        if ($signed(lead) > $signed(lag)) begin
                            deadline_reg <= now_reg - lag;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_res_reg.whole_ticks    <= ticks_reg;
                        m_res_reg.deadline_time  <= DATA_W'(deadline_reg);
                        m_res_reg.deadline_set   <= dl_valid_reg;
                        state_reg                <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    a_dl_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        dl_valid_reg |=> dl_valid_reg)
        else $error("deadline valid flag dropped");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (div_rem < rate_eff))
        else $error("remainder not below divisor");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide phase");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_MUL1 || state_reg == S_MUL2))
        else $error("multiplier finished outside multiply phase");

endmodule
